// ----- hw/rtl/dhcpv6_ia_address_extractor_macros.svh -----
// Assertion macros shared by the extractor's checker.
// No dependencies; include by bare file name.
`ifndef DHCPV6_IA_ADDRESS_EXTRACTOR_MACROS_SVH
`define DHCPV6_IA_ADDRESS_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DIAE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("extractor assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DIAE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("extractor assertion failed");

`endif

// ----- hw/rtl/diae_pkg.sv -----
// Shared types and constants for the DHCPv6 IA address extractor.
// No dependencies.
package diae_pkg;

    localparam int MAX_MESSAGE_BYTES_DEF = 65535;

    // Option codes
    localparam logic [15:0] OPT_IA_NA     = 16'd3;
    localparam logic [15:0] OPT_IA_TA     = 16'd4;
    localparam logic [15:0] OPT_IA_PD     = 16'd25;
    localparam logic [15:0] OPT_IAADDR    = 16'd5;
    localparam logic [15:0] OPT_IAPREFIX  = 16'd26;

    // Fixed part of each IA option left after its 4-byte option header
    localparam logic [15:0] IA_NA_FIXED   = 16'd12;
    localparam logic [15:0] IA_TA_FIXED   = 16'd4;
    localparam logic [15:0] IA_PD_FIXED   = 16'd12;

    // Capture byte indexes
    localparam logic [4:0]  ADDR_LAST_IDX = 5'd15;
    localparam logic [4:0]  PLEN_IDX      = 5'd8;
    localparam logic [4:0]  PFX_LAST_IDX  = 5'd24;
    localparam logic [4:0]  HDR_LAST_IDX  = 5'd3;

    // Index of the last message header byte before the first option
    localparam int MSG_HDR_LAST = 3;

    // IA kind codes
    localparam logic [1:0]  KIND_NA = 2'd0;
    localparam logic [1:0]  KIND_TA = 2'd1;
    localparam logic [1:0]  KIND_PD = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [1:0]  ia_kind;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  prefix_length;
    } t_out_item;

endpackage

// ----- hw/rtl/diae_parser.sv -----
// Per-byte option walker: holds parse state and forms the report for a last byte.
// Depends on diae_pkg.
module diae_parser #(
    parameter int MAX_MESSAGE_BYTES = diae_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  diae_pkg::t_in_item  i_item,
    output diae_pkg::t_out_item o_result
);
    import diae_pkg::*;

    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES);
    localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(MSG_HDR_LAST);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_OUTER_HDR,
        PH_OUTER_SKP,
        PH_IA_SKIP,
        PH_INNER_HDR,
        PH_INNER_SKP,
        PH_CAPTURE,
        PH_DONE
    } t_phase;

    logic [POS_W-1:0] r_pos,   n_pos;
    t_phase           r_phase, n_phase;
    logic [15:0]      r_code,  n_code;
    logic [15:0]      r_skip,  n_skip;
    logic [4:0]       r_fcnt,  n_fcnt;
    logic [127:0]     r_addr,  n_addr;
    logic [7:0]       r_plen,  n_plen;
    logic [1:0]       r_kind,  n_kind;
    logic             r_done,  n_done;

    logic [7:0]  b;
    logic        hdr_last;
    logic [15:0] want;

    assign b        = i_item.data_byte;
    assign hdr_last = (r_fcnt >= HDR_LAST_IDX);
    assign want     = (r_kind == KIND_PD) ? OPT_IAPREFIX : OPT_IAADDR;

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_code  = r_code;
        n_skip  = r_skip;
        n_fcnt  = r_fcnt;
        n_addr  = r_addr;
        n_plen  = r_plen;
        n_kind  = r_kind;
        n_done  = r_done;

        if (r_pos < POS_MAX) begin
            n_pos = r_pos + 1'b1;
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos >= POS_HDR_LAST) begin
                        n_phase = PH_OUTER_HDR;
                        n_fcnt  = '0;
                    end
                end
                PH_OUTER_HDR, PH_INNER_HDR: begin
                    // gather code then length, both big-endian
                    case (r_fcnt)
                        5'd0:    n_code = {b, 8'h00};
                        5'd1:    n_code = {r_code[15:8], b};
                        5'd2:    n_skip = {b, 8'h00};
                        default: n_skip = {r_skip[15:8], b};
                    endcase
                    n_fcnt = r_fcnt + 1'b1;
                    if (hdr_last) begin
                        n_fcnt = '0;
                        if (r_phase == PH_OUTER_HDR) begin
                            if (r_code == OPT_IA_NA) begin
                                n_kind  = KIND_NA;
                                n_skip  = IA_NA_FIXED;
                                n_phase = PH_IA_SKIP;
                            end else if (r_code == OPT_IA_TA) begin
                                n_kind  = KIND_TA;
                                n_skip  = IA_TA_FIXED;
                                n_phase = PH_IA_SKIP;
                            end else if (r_code == OPT_IA_PD) begin
                                n_kind  = KIND_PD;
                                n_skip  = IA_PD_FIXED;
                                n_phase = PH_IA_SKIP;
                            end else if (n_skip != 16'd0) begin
                                n_phase = PH_OUTER_SKP;
                            end
                        end else begin
                            if (r_code == want) begin
                                n_phase = PH_CAPTURE;
                                n_addr  = '0;
                                n_plen  = '0;
                            end else if (n_skip != 16'd0) begin
                                n_phase = PH_INNER_SKP;
                            end
                        end
                    end
                end
                PH_OUTER_SKP, PH_IA_SKIP, PH_INNER_SKP: begin
                    n_skip = r_skip - 16'd1;
                    if (n_skip == 16'd0) begin
                        n_fcnt  = '0;
                        n_phase = (r_phase == PH_OUTER_SKP) ? PH_OUTER_HDR : PH_INNER_HDR;
                    end
                end
                PH_CAPTURE: begin
                    if (r_kind == KIND_PD) begin
                        if (r_fcnt == PLEN_IDX) begin
                            n_plen = b;
                        end else if (r_fcnt > PLEN_IDX) begin
                            n_addr = {r_addr[119:0], b};
                        end
                        if (r_fcnt >= PFX_LAST_IDX) begin
                            n_done  = 1'b1;
                            n_phase = PH_DONE;
                        end
                    end else begin
                        n_addr = {r_addr[119:0], b};
                        if (r_fcnt >= ADDR_LAST_IDX) begin
                            n_done  = 1'b1;
                            n_phase = PH_DONE;
                        end
                    end
                    n_fcnt = r_fcnt + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // report from the state this byte leaves behind
    always_comb begin
        o_result.found         = n_done;
        o_result.ia_kind       = n_done ? n_kind : KIND_NA;
        o_result.addr_high     = n_done ? n_addr[127:64] : 64'd0;
        o_result.addr_low      = n_done ? n_addr[63:0] : 64'd0;
        o_result.prefix_length = (n_done && n_kind == KIND_PD) ? n_plen : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_HEADER;
            r_fcnt  <= '0;
            r_kind  <= KIND_NA;
            r_done  <= 1'b0;
        end else if (i_take) begin
            if (i_item.last_byte) begin
                // clear position, phase, count, kind and done after the report
                r_pos   <= '0;
                r_phase <= PH_HEADER;
                r_fcnt  <= '0;
                r_kind  <= KIND_NA;
                r_done  <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_fcnt  <= n_fcnt;
                r_kind  <= n_kind;
                r_done  <= n_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_code <= n_code;
            r_skip <= n_skip;
            r_addr <= n_addr;
            r_plen <= n_plen;
        end
    end

endmodule

// ----- hw/rtl/dhcpv6_ia_address_extractor.sv -----
// DHCPv6 IA address / delegated prefix extractor, byte-serial.
// Latency: the report is valid the cycle after the byte marked last is taken.
// Throughput: one message byte per cycle; the parse state updates in a single pass.
// The input stays ready while a report waits, unless that report is stalled.
// Reset: synchronous, active low; clears parse state and the report valid flag.
// Depends on diae_pkg and diae_parser.
module dhcpv6_ia_address_extractor #(
    parameter int MAX_MESSAGE_BYTES = diae_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  diae_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output diae_pkg::t_out_item o_out_data
);
    import diae_pkg::*;

    logic      take;
    t_out_item result;
    logic      r_out_valid;
    t_out_item r_out_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    diae_parser #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (i_in_data),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_in_data.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in_data.last_byte) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- hw/rtl/diae_checker.sv -----
// Port-level checks for the extractor, bound to the top level.
// Depends on diae_pkg and dhcpv6_ia_address_extractor_macros.svh.
`include "dhcpv6_ia_address_extractor_macros.svh"

module diae_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input diae_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input diae_pkg::t_out_item o_out_data
);
    import diae_pkg::*;

    // a taken last byte always produces a report next cycle
    `DIAE_ASSERT_NXT(a_last_reports, i_clk, i_rst_n, i_rst_n && i_in_valid && o_in_ready && i_in_data.last_byte, o_out_valid)

    // input stalls only behind a stalled report
    `DIAE_ASSERT_IMP(a_ready_stall, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

    // a miss reports all-zero fields
    `DIAE_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.found, o_out_data.ia_kind == KIND_NA && o_out_data.addr_high == 64'd0 && o_out_data.addr_low == 64'd0 && o_out_data.prefix_length == 8'd0)

    // prefix length only for delegation
    `DIAE_ASSERT_IMP(a_plen_pd, i_clk, i_rst_n, o_out_valid && o_out_data.ia_kind != KIND_PD, o_out_data.prefix_length == 8'd0)

    // a stalled report holds
    `DIAE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

endmodule

bind dhcpv6_ia_address_extractor diae_checker u_diae_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
